// File: rtl/core/assert_macros.svh
// -----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, disabled in reset.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/core/hsd_pkg.sv
// -----------------------------------------------------------------------------
// hsd_pkg
// Types and constants of the JPEG Huffman symbol decoder.
// -----------------------------------------------------------------------------
package hsd_pkg;

    localparam int MAX_CODE_LEN_DEF = 16;
    localparam int NUM_TABLES_DEF   = 4;
    localparam int MAX_SYMBOLS_DEF  = 256;

    localparam int CNT_W   = 8;   // count per length (one definition byte)
    localparam int CODE_W  = 17;  // canonical first code, saturating
    localparam int START_W = 9;   // first symbol index, saturating
    localparam int IDX_W   = 10;  // start + offset
    localparam int V_W     = 16;  // scan prefix, up to 16 bits

    localparam logic [CODE_W-1:0]  FIRST_SAT = 17'h1FFFF;
    localparam logic [START_W-1:0] POS_SAT   = 9'd511;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_DECODE = 1'b1;

    // Result of one length step of the canonical code walk.
    typedef struct packed {
        logic               hit;
        logic [IDX_W-1:0]   idx;
        logic [CODE_W-1:0]  code_next;
        logic [START_W-1:0] start_next;
    } step_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SCAN = 5'b00010,
        ST_SYM  = 5'b00100,
        ST_EXT  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

endpackage

// File: rtl/core/hsd_ram.sv
// -----------------------------------------------------------------------------
// hsd_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// -----------------------------------------------------------------------------
module hsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/hsd_len_step.sv
// -----------------------------------------------------------------------------
// hsd_len_step
// One length of the canonical walk: match test and next first code / start.
// -----------------------------------------------------------------------------
module hsd_len_step (
    input  logic [hsd_pkg::CNT_W-1:0]   cnt,
    input  logic [hsd_pkg::CODE_W-1:0]  first,
    input  logic [hsd_pkg::START_W-1:0] start,
    input  logic [hsd_pkg::V_W-1:0]     prefix,
    output hsd_pkg::step_t              res
);
    import hsd_pkg::*;

    logic [CODE_W:0]    diff;
    logic               ge;
    logic [CODE_W:0]    sum;
    logic [CODE_W+1:0]  shl;
    logic [START_W:0]   st_sum;

    always_comb
    begin
        diff   = {2'b0, prefix} - {1'b0, first};
        ge     = {1'b0, prefix} >= first;
        sum    = {1'b0, first} + {{(CODE_W+1-CNT_W){1'b0}}, cnt};
        shl    = {sum, 1'b0};
        st_sum = {1'b0, start} + {{(START_W+1-CNT_W){1'b0}}, cnt};

        res.hit        = (cnt != '0) && ge &&
                         (diff < {{(CODE_W+1-CNT_W){1'b0}}, cnt});
        res.idx        = {1'b0, start} + {{(IDX_W-CNT_W){1'b0}}, diff[CNT_W-1:0]};
        res.code_next  = (shl > {2'b0, FIRST_SAT}) ? FIRST_SAT : shl[CODE_W-1:0];
        res.start_next = (st_sum > {1'b0, POS_SAT}) ? POS_SAT : st_sum[START_W-1:0];
    end

endmodule

// File: rtl/core/jpeg_huffman_symbol_decoder.sv
// -----------------------------------------------------------------------------
// jpeg_huffman_symbol_decoder
// Canonical JPEG Huffman decoder: DHT byte loading and one-symbol decode.
// -----------------------------------------------------------------------------
//
//  Channel | Dir | Beat contents
//  --------+-----+------------------------------------------------------------
//  s_*     | in  | tdata: table_byte[7:0], bit_window[39:8]
//          |     | tuser: func[0], table_sel[2:1], start_table[3]
//  m_*     | out | tdata: symbol[7:0], code_length[12:8], extra_size[16:13],
//          |     |        coef_value[32:17], zero pad[39:33]; tuser: decode_error
//
//  Load beat: written straight to the count or symbol RAM.
//  Decode beat: lengths are walked one per cycle through the count RAM and a
//    single shared step unit; on a hit the symbol is read, its magnitude bits
//    are extended and the result beat is registered from the output state,
//    and the input is ready again in that same cycle. A miss walks every
//    length first; a symbol index past capacity or a bad table ends early.
//  Counts reset to zero through per-entry valid bits; no clearing pass.
//  Output stalls hold the finishing decode; no load is taken until it leaves.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module jpeg_huffman_symbol_decoder #(
    parameter int MAX_CODE_LEN = hsd_pkg::MAX_CODE_LEN_DEF,
    parameter int NUM_TABLES   = hsd_pkg::NUM_TABLES_DEF,
    parameter int MAX_SYMBOLS  = hsd_pkg::MAX_SYMBOLS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // table_byte[7:0], bit_window[39:8]
    input  logic [3:0]  s_tuser,   // func[0], table_sel[2:1], start_table[3]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // symbol, code_length, extra_size, coef_value
    output logic [0:0]  m_tuser    // decode_error
);
    import hsd_pkg::*;

    localparam int TBW     = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
    localparam int LW      = (MAX_CODE_LEN > 1) ? $clog2(MAX_CODE_LEN) : 1;
    localparam int SYM_AW  = $clog2(MAX_SYMBOLS);
    localparam int CNT_AW  = TBW + LW;
    localparam int SYM_RAW = TBW + SYM_AW;

    localparam logic [3:0]         NT      = 4'(NUM_TABLES);
    localparam logic [8:0]         MCL9    = 9'(MAX_CODE_LEN);
    localparam logic [8:0]         MSYM9   = 9'(MAX_SYMBOLS);
    localparam logic [IDX_W-1:0]   MSYM_I  = IDX_W'(MAX_SYMBOLS);
    localparam logic [LW-1:0]      LAST_L  = LW'(MAX_CODE_LEN - 1);

    // input fields
    logic        in_func;
    logic [1:0]  in_sel;
    logic        in_start;
    logic [7:0]  in_byte;
    logic [31:0] in_win;
    logic        s_fire;

    assign in_func  = s_tuser[0];
    assign in_sel   = s_tuser[2:1];
    assign in_start = s_tuser[3];
    assign in_byte  = s_tdata[7:0];
    assign in_win   = s_tdata[39:8];

    // control state
    state_t                              state_reg, state_next;
    logic [1:0]                          load_table_reg, load_table_next;
    logic [8:0]                          load_pos_reg, load_pos_next;
    logic [NUM_TABLES-1:0][MAX_CODE_LEN-1:0] cnt_vld_reg, cnt_vld_next;
    logic                                m_valid_reg, m_valid_next;

    // decode datapath
    logic [TBW-1:0]     tbl_reg, tbl_next;
    logic [LW-1:0]      len_reg, len_next;
    logic [CODE_W-1:0]  first_reg, first_next;
    logic [START_W-1:0] start_reg, start_next;
    logic [V_W-1:0]     prefix_reg, prefix_next;
    logic [31:0]        win_reg, win_next;
    logic [7:0]         sym_reg, sym_next;
    logic [14:0]        bits_reg, bits_next;

    // pending result and output beat
    logic [7:0]  res_sym_reg, res_sym_next;
    logic [4:0]  res_len_reg, res_len_next;
    logic [3:0]  res_size_reg, res_size_next;
    logic [15:0] res_val_reg, res_val_next;
    logic        res_err_reg, res_err_next;
    logic [39:0] m_data_reg, m_data_next;
    logic        m_err_reg, m_err_next;

    // load decode
    logic [1:0]  eff_tbl;
    logic [8:0]  eff_pos;
    logic [8:0]  sym_pos;
    logic        tbl_ok;
    logic        cnt_we;
    logic        sym_we;

    // RAM ports
    logic [CNT_AW-1:0]  cnt_waddr, cnt_raddr;
    logic [CNT_W-1:0]   cnt_rdata, cnt_cur;
    logic [SYM_RAW-1:0] sym_waddr, sym_raddr;
    logic [7:0]         sym_rdata;

    step_t       stp;
    logic [3:0]  ext_size;
    logic [15:0] ext_bits, ext_half, ext_full;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_err_reg;

    // Load path: a start byte restarts the position and retargets the table.
    always_comb
    begin
        eff_tbl   = in_start ? in_sel : load_table_reg;
        eff_pos   = in_start ? 9'd0 : load_pos_reg;
        sym_pos   = eff_pos - MCL9;
        tbl_ok    = {2'b0, eff_tbl} < NT;
        cnt_we    = s_fire && (in_func == FUNC_LOAD) && tbl_ok && (eff_pos < MCL9);
        sym_we    = s_fire && (in_func == FUNC_LOAD) && tbl_ok && (eff_pos >= MCL9) &&
                    (sym_pos < MSYM9);
        cnt_waddr = {TBW'(eff_tbl), LW'(eff_pos)};
        sym_waddr = {TBW'(eff_tbl), SYM_AW'(sym_pos)};
    end

    // Count read: length 1 is fetched in the accept cycle, then one ahead.
    assign cnt_raddr = (state_reg == ST_IDLE) ? {TBW'(in_sel), {LW{1'b0}}}
                                              : {tbl_reg, LW'(len_reg + 1'b1)};
    assign cnt_cur   = cnt_vld_reg[tbl_reg][len_reg] ? cnt_rdata : '0;
    assign sym_raddr = {tbl_reg, stp.idx[SYM_AW-1:0]};

    hsd_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NUM_TABLES << LW)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (in_byte),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    hsd_ram #(
        .WIDTH (8),
        .DEPTH (NUM_TABLES << SYM_AW)
    ) u_sym_ram (
        .clk   (clk),
        .we    (sym_we),
        .waddr (sym_waddr),
        .wdata (in_byte),
        .raddr (sym_raddr),
        .rdata (sym_rdata)
    );

    hsd_len_step u_step (
        .cnt    (cnt_cur),
        .first  (first_reg),
        .start  (start_reg),
        .prefix (prefix_reg),
        .res    (stp)
    );

    // JPEG extension of the magnitude bits
    always_comb
    begin
        ext_size = sym_reg[3:0];
        ext_bits = {1'b0, bits_reg};
        ext_half = 16'd1 << (ext_size - 4'd1);
        ext_full = 16'd1 << ext_size;
    end

    always_comb
    begin
        state_next      = state_reg;
        load_table_next = load_table_reg;
        load_pos_next   = load_pos_reg;
        cnt_vld_next    = cnt_vld_reg;
        m_valid_next    = m_valid_reg;
        tbl_next        = tbl_reg;
        len_next        = len_reg;
        first_next      = first_reg;
        start_next      = start_reg;
        prefix_next     = prefix_reg;
        win_next        = win_reg;
        sym_next        = sym_reg;
        bits_next       = bits_reg;
        res_sym_next    = res_sym_reg;
        res_len_next    = res_len_reg;
        res_size_next   = res_size_reg;
        res_val_next    = res_val_reg;
        res_err_next    = res_err_reg;
        m_data_next     = m_data_reg;
        m_err_next      = m_err_reg;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        // table load bookkeeping
        if (s_fire && (in_func == FUNC_LOAD))
        begin
            if (in_start)
            begin
                load_table_next = in_sel;
                if (tbl_ok)
                begin
                    cnt_vld_next[TBW'(eff_tbl)] = '0;
                end
            end
            if (cnt_we)
            begin
                cnt_vld_next[TBW'(eff_tbl)][LW'(eff_pos)] = 1'b1;
            end
            load_pos_next = (eff_pos < POS_SAT) ? eff_pos + 9'd1 : eff_pos;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire && (in_func == FUNC_DECODE))
                begin
                    tbl_next    = TBW'(in_sel);
                    len_next    = '0;
                    first_next  = '0;
                    start_next  = '0;
                    prefix_next = {{(V_W-1){1'b0}}, in_win[31]};
                    win_next    = {in_win[30:0], 1'b0};
                    // error defaults, overwritten on a hit
                    res_sym_next  = '0;
                    res_len_next  = '0;
                    res_size_next = '0;
                    res_val_next  = '0;
                    res_err_next  = 1'b1;
                    state_next    = ({2'b0, in_sel} < NT) ? ST_SCAN : ST_OUT;
                end
            end
            ST_SCAN:
            begin
                if (stp.hit)
                begin
                    // index past table capacity is a miss
                    state_next = (stp.idx >= MSYM_I) ? ST_OUT : ST_SYM;
                end
                else if (len_reg == LAST_L)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    len_next    = len_reg + 1'b1;
                    first_next  = stp.code_next;
                    start_next  = stp.start_next;
                    prefix_next = {prefix_reg[V_W-2:0], win_reg[31]};
                    win_next    = {win_reg[30:0], 1'b0};
                end
            end
            ST_SYM:
            begin
                // win_reg now starts at the first magnitude bit
                sym_next  = sym_rdata;
                bits_next = 15'(win_reg >> (6'd32 - {2'b0, sym_rdata[3:0]}));
            end
            ST_EXT:
            begin
                res_sym_next  = sym_reg;
                res_len_next  = 5'(len_reg) + 5'd1;
                res_size_next = ext_size;
                res_err_next  = 1'b0;
                if (ext_size == 4'd0)
                begin
                    res_val_next = '0;
                end
                else if (ext_bits < ext_half)
                begin
                    res_val_next = ext_bits - ext_full + 16'd1;
                end
                else
                begin
                    res_val_next = ext_bits;
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {7'b0, res_val_reg, res_size_reg, res_len_reg,
                                    res_sym_reg};
                    m_err_next   = res_err_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (state_reg == ST_SYM)
        begin
            state_next = ST_EXT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            load_table_reg <= '0;
            load_pos_reg   <= '0;
            cnt_vld_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            load_table_reg <= load_table_next;
            load_pos_reg   <= load_pos_next;
            cnt_vld_reg    <= cnt_vld_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tbl_reg      <= tbl_next;
        len_reg      <= len_next;
        first_reg    <= first_next;
        start_reg    <= start_next;
        prefix_reg   <= prefix_next;
        win_reg      <= win_next;
        sym_reg      <= sym_next;
        bits_reg     <= bits_next;
        res_sym_reg  <= res_sym_next;
        res_len_reg  <= res_len_next;
        res_size_reg <= res_size_next;
        res_val_reg  <= res_val_next;
        res_err_reg  <= res_err_next;
        m_data_reg   <= m_data_next;
        m_err_reg    <= m_err_next;
    end

    // a hit always reports a length within the configured range
    `ASSERT_IMP(a_hit_len, m_valid_reg && !m_err_reg,
        (m_data_reg[12:8] != 5'd0) && (m_data_reg[12:8] <= 5'(MAX_CODE_LEN)))
    // a miss carries all-zero fields
    `ASSERT_IMP(a_miss_zero, m_valid_reg && m_err_reg, m_data_reg[32:0] == '0)
    // extra size is the symbol's low nibble
    `ASSERT_IMP(a_size_nibble, m_valid_reg, m_data_reg[16:13] == m_data_reg[3:0])
    // a new beat is only launched from the output state
    `ASSERT_NXT(a_launch, !m_valid_reg && (state_reg != ST_OUT), !m_valid_reg)

endmodule
